// ===== sv/alm_tbl_pkg.sv =====
// Shared types and codes for the daily alarm table.
// Used by multi_slot_daily_alarm_table_top and the testbench files; depends on nothing.
`timescale 1ns / 1ps

package alm_tbl_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  localparam logic [4:0] MAX_HOUR   = 5'd24;
  localparam logic [5:0] MAX_MINUTE = 6'd59;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_EDIT   = 3'd1,
    OP_DELETE = 3'd2,
    OP_TICK   = 3'd3,
    OP_STOP   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_TIME  = 3'd1,
    ST_FULL  = 3'd2,
    ST_INDEX = 3'd3,
    ST_BUSY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } seq_state_t;

endpackage

// ===== sv/multi_slot_daily_alarm_table_top.sv =====
// Daily alarm table: slot storage, slot-by-slot sequencer and result strobe.
// Depends on alm_tbl_pkg.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive operation, hour, minute, slot_index and day and
//   raise start; the beat is taken at a rising edge with start high and busy
//   low. busy stays high while the sequencer works on a beat.
//   Result channel: done is high for exactly one cycle with status, ringing,
//   ringing_slot and slot_count valid in that cycle. The receiver cannot
//   stall; a result not taken in its cycle is gone.
//   Add, edit, stop, refused and unknown commands and a delete with a bad
//   index need no walk: done is raised in the cycle after the accept.
//   A tick walks the used slots one per cycle through a single shared
//   compare and ends at the first unfired match or past the last used slot.
//   A delete walks from the deleted slot to the end of the table, moving
//   one slot down per cycle.
//   Throughput: one command at a time; a new command may be accepted in the
//   same cycle that done shows the previous result.
//   Reset (rst, synchronous, active high): the table is emptied, ringing ends
//   and the day is zero. Slot contents are not cleared; only slots below the
//   used count are ever read.

module multi_slot_daily_alarm_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    operation,
  input  logic [4:0]                    hour,
  input  logic [5:0]                    minute,
  input  logic [alm_tbl_pkg::IDX_W-1:0] slot_index,
  input  logic [4:0]                    day,
  output logic                          done,
  output logic [2:0]                    status,
  output logic                          ringing,
  output logic [alm_tbl_pkg::IDX_W-1:0] ringing_slot,
  output logic [alm_tbl_pkg::CNT_W-1:0] slot_count
);
  import alm_tbl_pkg::*;

  // Slot storage; read at one sequencer address per cycle.
  logic [4:0]       hours   [SLOTS];
  logic [5:0]       minutes [SLOTS];
  logic [SLOTS-1:0] fired;

  logic [CNT_W-1:0] used_count;
  logic [4:0]       current_day;
  logic             ring_active;
  logic [IDX_W-1:0] ring_slot;

  seq_state_t       state;
  logic [CNT_W-1:0] ptr;
  logic [4:0]       hour_q;
  logic [5:0]       minute_q;
  status_t          status_q;

  logic             accept;
  logic             time_ok;
  logic             idx_ok;
  logic [CNT_W-1:0] ptr_inc;
  logic [IDX_W-1:0] rd_idx;
  logic             slot_hit;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign time_ok = (hour <= MAX_HOUR) && (minute <= MAX_MINUTE);
  assign idx_ok  = ({1'b0, slot_index} < used_count);
  assign ptr_inc = ptr + CNT_W'(1);

  // Shift reads the slot above the pointer, the scan reads the pointer itself.
  assign rd_idx   = (state == S_SHIFT) ? ptr_inc[IDX_W-1:0] : ptr[IDX_W-1:0];
  assign slot_hit = (hours[rd_idx] == hour_q) && (minutes[rd_idx] == minute_q) &&
                    !fired[rd_idx];

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      used_count  <= '0;
      current_day <= '0;
      ring_active <= 1'b0;
      ring_slot   <= '0;
      ptr         <= '0;
      status_q    <= ST_OK;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            status_q <= ST_OK;
            done     <= 1'b1;
            if (operation <= OP_TICK && ring_active) begin
              status_q <= ST_BUSY;
            end else begin
              case (operation)
                OP_ADD: begin
                  if (!time_ok) begin
                    status_q <= ST_TIME;
                  end else if (used_count >= CNT_W'(SLOTS)) begin
                    status_q <= ST_FULL;
                  end else begin
                    used_count <= used_count + CNT_W'(1);
                  end
                end
                OP_EDIT: begin
                  if (!time_ok) begin
                    status_q <= ST_TIME;
                  end else if (!idx_ok) begin
                    status_q <= ST_INDEX;
                  end
                end
                OP_DELETE: begin
                  if (!idx_ok) begin
                    status_q <= ST_INDEX;
                  end else begin
                    // Walk the later slots down one at a time.
                    done  <= 1'b0;
                    ptr   <= {1'b0, slot_index};
                    state <= S_SHIFT;
                  end
                end
                OP_TICK: begin
                  if (day != current_day) begin
                    current_day <= day;
                  end
                  done  <= 1'b0;
                  ptr   <= '0;
                  state <= S_SCAN;
                end
                OP_STOP: begin
                  ring_active <= 1'b0;
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_SCAN: begin
          if (ptr >= used_count) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (slot_hit) begin
            ring_active <= 1'b1;
            ring_slot   <= ptr[IDX_W-1:0];
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_SHIFT: begin
          if (ptr_inc >= used_count) begin
            used_count <= used_count - CNT_W'(1);
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            ptr <= ptr_inc;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Slot storage and latched tick time; no reset needed.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && !(operation <= OP_TICK && ring_active)) begin
      hour_q   <= hour;
      minute_q <= minute;
      case (operation)
        OP_ADD: begin
          if (time_ok && used_count < CNT_W'(SLOTS)) begin
            hours[used_count[IDX_W-1:0]]   <= hour;
            minutes[used_count[IDX_W-1:0]] <= minute;
            fired[used_count[IDX_W-1:0]]   <= 1'b0;
          end
        end
        OP_EDIT: begin
          if (time_ok && idx_ok) begin
            hours[slot_index]   <= hour;
            minutes[slot_index] <= minute;
          end
        end
        OP_TICK: begin
          // New day: drop every fired mark before the scan starts.
          if (day != current_day) begin
            fired <= '0;
          end
        end
        OP_STOP: begin
          if (ring_active) begin
            fired[ring_slot] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_SHIFT && ptr_inc < used_count) begin
      hours[ptr[IDX_W-1:0]]   <= hours[rd_idx];
      minutes[ptr[IDX_W-1:0]] <= minutes[rd_idx];
      fired[ptr[IDX_W-1:0]]   <= fired[rd_idx];
    end
  end

  // Result beat: state fields reflect the table as the command left it.
  assign status       = status_q;
  assign ringing      = ring_active;
  assign ringing_slot = ring_active ? ring_slot : '0;
  assign slot_count   = used_count;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(SLOTS))
    else $error("slot count above table size");

  a_ring_in_table: assert property (@(posedge clk) disable iff (rst)
    ring_active |-> ({1'b0, ring_slot} < used_count))
    else $error("ringing slot outside used table");

  a_scan_not_ringing: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ring_active)
    else $error("tick scan while ringing");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(state == S_SCAN) || $past(state == S_SHIFT)))
    else $error("result without a command");

  a_count_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    (used_count != $past(used_count)) |-> done)
    else $error("slot count changed without a result");
`endif

endmodule

// ===== tb/alarm_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the daily alarm table: follows the command and result channels,
// keeps its own copy of the slot table and compares every result beat.
// Depends on alm_tbl_pkg.

module alarm_table_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    operation,
  input  logic [4:0]                    hour,
  input  logic [5:0]                    minute,
  input  logic [alm_tbl_pkg::IDX_W-1:0] slot_index,
  input  logic [4:0]                    day,
  input  logic                          done,
  input  logic [2:0]                    status,
  input  logic                          ringing,
  input  logic [alm_tbl_pkg::IDX_W-1:0] ringing_slot,
  input  logic [alm_tbl_pkg::CNT_W-1:0] slot_count,
  output int                            fail_count,
  output int                            pending,
  output int                            results_checked,
  output int                            rings_seen
);
  import alm_tbl_pkg::*;

  typedef struct packed {
    status_t          status;
    logic             ringing;
    logic [IDX_W-1:0] ring_slot;
    logic [CNT_W-1:0] count;
  } alarm_outcome_t;

  logic [4:0]       slot_hr    [SLOTS];
  logic [5:0]       slot_min   [SLOTS];
  logic             slot_fired [SLOTS];
  int               used;
  logic [4:0]       today;
  logic             ring_on;
  logic [IDX_W-1:0] ring_at;
  alarm_outcome_t   outcome_q[$];
  int               mismatches;
  int               checked;
  int               rings;

  function automatic logic time_valid(logic [4:0] h, logic [5:0] m);
    return (h <= MAX_HOUR) && (m <= MAX_MINUTE);
  endfunction

  // Apply one command to the shadow table and return the result it should give.
  function automatic alarm_outcome_t predict_outcome(logic [2:0] op, logic [4:0] h,
                                                    logic [5:0] m, logic [IDX_W-1:0] idx,
                                                    logic [4:0] d);
    alarm_outcome_t r;
    r.status = ST_OK;
    if (op <= OP_TICK && ring_on) begin
      r.status = ST_BUSY;
    end else begin
      case (op)
        OP_ADD: begin
          if (!time_valid(h, m)) begin
            r.status = ST_TIME;
          end else if (used >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            slot_hr[used]    = h;
            slot_min[used]   = m;
            slot_fired[used] = 1'b0;
            used++;
          end
        end
        OP_EDIT: begin
          if (!time_valid(h, m)) begin
            r.status = ST_TIME;
          end else if (int'(idx) >= used) begin
            r.status = ST_INDEX;
          end else begin
            slot_hr[idx]  = h;
            slot_min[idx] = m;
          end
        end
        OP_DELETE: begin
          if (int'(idx) >= used) begin
            r.status = ST_INDEX;
          end else begin
            for (int i = int'(idx); i + 1 < used; i++) begin
              slot_hr[i]    = slot_hr[i + 1];
              slot_min[i]   = slot_min[i + 1];
              slot_fired[i] = slot_fired[i + 1];
            end
            used--;
          end
        end
        OP_TICK: begin
          if (d != today) begin
            today = d;
            for (int i = 0; i < used; i++) slot_fired[i] = 1'b0;
          end
          for (int i = 0; i < used; i++) begin
            if (!ring_on && slot_hr[i] == h && slot_min[i] == m && !slot_fired[i]) begin
              ring_on = 1'b1;
              ring_at = IDX_W'(i);
              rings++;
            end
          end
        end
        OP_STOP: begin
          if (ring_on) begin
            slot_fired[ring_at] = 1'b1;
            ring_on = 1'b0;
          end
        end
        default: ;
      endcase
    end
    r.ringing   = ring_on;
    r.ring_slot = ring_on ? ring_at : '0;
    r.count     = CNT_W'(used);
    return r;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    alarm_outcome_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_hr[i]    = '0;
        slot_min[i]   = '0;
        slot_fired[i] = 1'b0;
      end
      used    = 0;
      today   = '0;
      ring_on = 1'b0;
      ring_at = '0;
      outcome_q.delete();
    end else begin
      // Check the result beat before taking a new command: the block may show
      // a result and accept the next command at the same edge.
      if (done) begin
        checked++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no command outstanding (status %0d)", $time,
                   status);
        end else begin
          want = outcome_q.pop_front();
          compare_field("status", want.status, status);
          compare_field("ringing", want.ringing, ringing);
          compare_field("ringing_slot", want.ring_slot, ringing_slot);
          compare_field("slot_count", want.count, slot_count);
        end
      end
      if (start && !busy)
        outcome_q.push_back(predict_outcome(operation, hour, minute, slot_index, day));
    end
    fail_count      <= mismatches;
    pending         <= outcome_q.size();
    results_checked <= checked;
    rings_seen      <= rings;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the daily alarm table testbench: clock, reset, command stimulus and
// verdict. Depends on alm_tbl_pkg, alarm_table_checker and the block itself.

module testbench;
  import alm_tbl_pkg::*;

  // Codes past OP_STOP are unused; the block must answer them with OK.
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_CODE    = 3'd7;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [2:0]       operation;
  logic [4:0]       hour;
  logic [5:0]       minute;
  logic [IDX_W-1:0] slot_index;
  logic [4:0]       day;
  logic             done;
  logic [2:0]       status;
  logic             ringing;
  logic [IDX_W-1:0] ringing_slot;
  logic [CNT_W-1:0] slot_count;

  int fail_count;
  int pending;
  int results_checked;
  int rings_seen;

  // Percent chance of an idle cycle before each command beat.
  int idle_pct;
  int beats_sent;

  // Rough picture of the table, only used to aim ticks and indexes; the
  // checker holds the real prediction.
  logic [10:0] known_times[$];
  logic [4:0]  known_day;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_slot_daily_alarm_table_top uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .hour        (hour),
    .minute      (minute),
    .slot_index  (slot_index),
    .day         (day),
    .done        (done),
    .status      (status),
    .ringing     (ringing),
    .ringing_slot(ringing_slot),
    .slot_count  (slot_count)
  );

  alarm_table_checker table_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .hour           (hour),
    .minute         (minute),
    .slot_index     (slot_index),
    .day            (day),
    .done           (done),
    .status         (status),
    .ringing        (ringing),
    .ringing_slot   (ringing_slot),
    .slot_count     (slot_count),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .rings_seen     (rings_seen)
  );

  // Drive one command beat and hold it until the block takes it. Called just
  // after a rising edge; returns at the edge that accepted the beat, with
  // start still high so the next beat can follow back to back.
  task automatic issue(input logic [2:0] op, input logic [4:0] h, input logic [5:0] m,
                       input logic [IDX_W-1:0] idx, input logic [4:0] d);
    int n;
    n = known_times.size();
    // Drop start for a random number of cycles first.
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    operation  <= op;
    hour       <= h;
    minute     <= m;
    slot_index <= idx;
    day        <= d;
    // busy read right after the edge is its value at that edge.
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    case (op)
      OP_ADD:
        if (h <= MAX_HOUR && m <= MAX_MINUTE && n < SLOTS) known_times.push_back({h, m});
      OP_EDIT:
        if (h <= MAX_HOUR && m <= MAX_MINUTE && int'(idx) < n) known_times[idx] = {h, m};
      OP_DELETE:
        if (int'(idx) < n) known_times.delete(int'(idx));
      OP_TICK:
        known_day = d;
      default: ;
    endcase
  endtask

  // Mostly legal times, aimed indexes and ticks that hit stored alarms, so
  // that rings, stops, full tables and shifts all happen often; the rest is
  // out-of-range times, stray indexes and day changes.
  task automatic random_command();
    int          pick;
    int          n;
    logic [2:0]  op;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [3:0]  idx;
    logic [4:0]  d;
    pick = $urandom_range(99);
    n    = known_times.size();
    h    = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 25)) : 5'($urandom_range(24));
    m    = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 60)) : 6'($urandom_range(59));
    idx  = (n > 0 && $urandom_range(9) < 7) ? 4'($urandom_range(n - 1)) : 4'($urandom);
    d    = known_day;
    if (pick < 24) begin
      op = OP_ADD;
    end else if (pick < 36) begin
      op = OP_EDIT;
    end else if (pick < 48) begin
      op = OP_DELETE;
    end else if (pick < 78) begin
      op = OP_TICK;
      if (n > 0 && $urandom_range(9) < 6) {h, m} = known_times[$urandom_range(n - 1)];
      if ($urandom_range(9) < 2) d = 5'($urandom);
    end else if (pick < 94) begin
      op = OP_STOP;
    end else begin
      op = 3'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED));
    end
    issue(op, h, m, idx, d);
  endtask

  initial begin
    int phase_idle[3];
    rst        <= 1'b1;
    start      <= 1'b0;
    operation  <= OP_ADD;
    hour       <= '0;
    minute     <= '0;
    slot_index <= '0;
    day        <= '0;
    idle_pct   = 0;
    beats_sent = 0;
    known_day  = '0;
    phase_idle = '{0, 57, 24};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, back to back.
    issue(OP_DELETE, 5'd0, 6'd0, 4'd0, 5'd0);      // delete on an empty table
    issue(OP_ADD, 5'd0, 6'd0, 4'd0, 5'd0);         // earliest time
    issue(OP_ADD, MAX_HOUR, MAX_MINUTE, 4'd0, 5'd0); // latest time
    issue(OP_ADD, 5'd25, 6'd0, 4'd0, 5'd0);        // hour just out of range
    issue(OP_ADD, 5'd0, 6'd60, 4'd0, 5'd0);        // minute just out of range
    issue(OP_ADD, 5'd31, 6'd63, 4'd15, 5'd31);     // all ones
    issue(OP_EDIT, 5'd31, 6'd0, 4'd15, 5'd0);      // bad time wins over bad index
    issue(OP_EDIT, 5'd3, 6'd4, 4'd2, 5'd0);        // index past the end
    issue(OP_DELETE, 5'd0, 6'd0, 4'd2, 5'd0);      // index past the end
    issue(OP_EDIT, 5'd0, 6'd0, 4'd1, 5'd0);        // two slots now at 00:00
    issue(OP_TICK, 5'd0, 6'd0, 4'd0, 5'd0);        // first match rings
    issue(OP_ADD, 5'd1, 6'd1, 4'd0, 5'd0);         // refused while ringing
    issue(OP_EDIT, 5'd1, 6'd1, 4'd0, 5'd0);
    issue(OP_DELETE, 5'd0, 6'd0, 4'd0, 5'd0);
    issue(OP_TICK, 5'd0, 6'd0, 4'd0, 5'd5);        // day change not seen yet
    issue(OP_LAST_CODE, 5'd0, 6'd0, 4'd0, 5'd0);   // unused code while ringing
    issue(OP_STOP, 5'd0, 6'd0, 4'd0, 5'd0);
    issue(OP_TICK, 5'd0, 6'd0, 4'd0, 5'd0);        // fired slot skipped, next rings
    issue(OP_STOP, 5'd0, 6'd0, 4'd0, 5'd0);
    issue(OP_TICK, 5'd0, 6'd0, 4'd0, 5'd0);        // both fired, no ring
    issue(OP_EDIT, 5'd12, 6'd30, 4'd1, 5'd0);      // fired flag survives the edit
    issue(OP_TICK, 5'd12, 6'd30, 4'd0, 5'd0);
    issue(OP_TICK, 5'd12, 6'd30, 4'd0, 5'd31);     // new day clears flags, rings
    issue(OP_STOP, 5'd0, 6'd0, 4'd0, 5'd31);
    issue(OP_DELETE, 5'd0, 6'd0, 4'd0, 5'd31);     // fired flag shifts down
    issue(OP_TICK, 5'd12, 6'd30, 4'd0, 5'd31);
    issue(OP_STOP, 5'd0, 6'd0, 4'd0, 5'd31);       // stop while idle
    // Fill the table, overflow it, then trim both ends.
    repeat (16) issue(OP_ADD, 5'($urandom_range(24)), 6'($urandom_range(59)), 4'd0, 5'd31);
    issue(OP_DELETE, 5'd0, 6'd0, 4'd15, 5'd31);
    issue(OP_DELETE, 5'd0, 6'd0, 4'd0, 5'd31);
    issue(OP_FIRST_UNUSED, 5'd0, 6'd0, 4'd0, 5'd31);

    // Random part: one phase per sender idle rate.
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      repeat (135) random_command();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Every expected result is in; keep clocking so a stray extra result beat is still caught.
    repeat (40) @(posedge clk);

    $display("Sent %0d command beats across idle rates of 0, 57 and 24 percent;", beats_sent);
    $display("checked %0d result beats, %0d alarms started ringing.", results_checked,
             rings_seen);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/alm_tbl_pkg.sv
sv/multi_slot_daily_alarm_table_top.sv
tb/alarm_table_checker.sv
tb/testbench.sv
